/* rtl/bes_pkg.sv */
// shared constants, types and weight tables for the bilinear element stiffness pipeline
`timescale 1ns / 1ps
package bes_pkg;

	localparam int WORD_W = 32;
	localparam int K_W    = 31;
	localparam int LEN_W  = WORD_W + 1;
	localparam int MAG_W  = WORD_W + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int WT_W   = K_W + 5;
	localparam int LO_W   = MAG_W;
	localparam int HI_W   = SQ_W - LO_W;
	localparam int PP_W   = WT_W + LO_W + 1;
	localparam int NUM_W  = 2 * WORD_W + WT_W + 2;
	localparam int MAGN_W = NUM_W - 1;
	localparam int DEN_W  = SQ_W + 5;
	localparam int CMP_W  = DEN_W + WORD_W;
	localparam int N_ENT  = 10;
	localparam int N_NODE = 4;
	localparam int DIV_LAT = WORD_W + 2;

	typedef logic [N_NODE-1:0][K_W-1:0] coeff_vec_t;

	typedef struct packed {
		logic [N_ENT-1:0][WORD_W-1:0] m;
		logic                         degenerate;
		logic                         saturated;
	} res_t;

	// per entry and node: weight of lx^2 and of ly^2
	localparam int WT_X [N_ENT][N_NODE] = '{
		'{ 3,  1,  1,  3}, '{ 1,  1,  1,  1}, '{-1, -1, -1, -1}, '{-3, -1, -1, -3},
		'{ 1,  3,  3,  1}, '{-1, -3, -3, -1}, '{-1, -1, -1, -1}, '{ 1,  3,  3,  1},
		'{ 1,  1,  1,  1}, '{ 3,  1,  1,  3}
	};
	localparam int WT_Y [N_ENT][N_NODE] = '{
		'{ 3,  3,  1,  1}, '{-3, -3, -1, -1}, '{-1, -1, -1, -1}, '{ 1,  1,  1,  1},
		'{ 3,  3,  1,  1}, '{ 1,  1,  1,  1}, '{-1, -1, -1, -1}, '{ 1,  1,  3,  3},
		'{-1, -1, -3, -3}, '{ 1,  1,  3,  3}
	};

	function automatic logic signed [WT_W-1:0] wsum(coeff_vec_t k, int e, logic axis_y);
		logic signed [WT_W-1:0] acc;
		int w;
		acc = '0;
		for (int i = 0; i < N_NODE; i++) begin
			w = axis_y ? WT_Y[e][i] : WT_X[e][i];
			acc = acc + $signed(WT_W'(k[i])) * $signed(WT_W'(w));
		end
		return acc;
	endfunction

endpackage

/* rtl/bes_in_if.sv */
// element channel: corner coordinates and nodal coefficients
`timescale 1ns / 1ps
interface bes_in_if;
	import bes_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] x_left;
	logic signed [WORD_W-1:0] y_bottom;
	logic signed [WORD_W-1:0] x_right;
	logic signed [WORD_W-1:0] y_top;
	logic [K_W-1:0]           coeff_a;
	logic [K_W-1:0]           coeff_b;
	logic [K_W-1:0]           coeff_c;
	logic [K_W-1:0]           coeff_d;

	modport source (output valid, x_left, y_bottom, x_right, y_top,
		coeff_a, coeff_b, coeff_c, coeff_d, input ready);
	modport sink (input valid, x_left, y_bottom, x_right, y_top,
		coeff_a, coeff_b, coeff_c, coeff_d, output ready);
endinterface

/* rtl/bes_out_if.sv */
// matrix channel: ten upper-triangle entries and flags
`timescale 1ns / 1ps
interface bes_out_if;
	import bes_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] m00;
	logic signed [WORD_W-1:0] m01;
	logic signed [WORD_W-1:0] m02;
	logic signed [WORD_W-1:0] m03;
	logic signed [WORD_W-1:0] m11;
	logic signed [WORD_W-1:0] m12;
	logic signed [WORD_W-1:0] m13;
	logic signed [WORD_W-1:0] m22;
	logic signed [WORD_W-1:0] m23;
	logic signed [WORD_W-1:0] m33;
	logic                     degenerate;
	logic                     saturated;

	modport source (output valid, m00, m01, m02, m03, m11, m12, m13, m22, m23, m33,
		degenerate, saturated, input ready);
	modport sink (input valid, m00, m01, m02, m03, m11, m12, m13, m22, m23, m33,
		degenerate, saturated, output ready);
endinterface

/* rtl/bes_div.sv */
// pipelined restoring divider with round-half-away and signed saturation
`timescale 1ns / 1ps
module bes_div import bes_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [MAGN_W-1:0]        mag,
	input  logic [DEN_W-1:0]         den,
	input  logic                     neg,
	output logic signed [WORD_W-1:0] quo,
	output logic                     sat
);

	logic [MAGN_W-1:0] rem_s  [WORD_W+1];
	logic [DEN_W-1:0]  den_s  [WORD_W+1];
	logic [WORD_W-1:0] q_s    [WORD_W+1];
	logic              neg_s  [WORD_W+1];
	logic              over_s [WORD_W+1];

	// quotient of 2^WORD_W or more is clipped anyway
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= mag;
			den_s[0]  <= den;
			neg_s[0]  <= neg;
			over_s[0] <= CMP_W'(mag) >= (CMP_W'(den) << WORD_W);
			q_s[0]    <= '0;
		end
	end

	for (genvar j = 1; j <= WORD_W; j++) begin : g_bit
		localparam int B = WORD_W - j;
		logic [CMP_W-1:0]  t;
		logic              ge;
		logic [WORD_W-1:0] qn;
		always_comb begin
			t = CMP_W'(den_s[j-1]) << B;
			ge = CMP_W'(rem_s[j-1]) >= t;
			qn = q_s[j-1];
			qn[B] = ge;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? MAGN_W'(CMP_W'(rem_s[j-1]) - t) : rem_s[j-1];
				den_s[j]  <= den_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				over_s[j] <= over_s[j-1];
				q_s[j]    <= qn;
			end
		end
	end

	logic [WORD_W:0] q_rnd, q_fin, lim;
	logic            clip;
	always_comb begin
		q_rnd = {1'b0, q_s[WORD_W]} + (WORD_W+1)'((CMP_W'(rem_s[WORD_W]) << 1)
			>= CMP_W'(den_s[WORD_W]));
		if (over_s[WORD_W])
			q_rnd = (WORD_W+1)'(1) << WORD_W;
		lim = ((WORD_W+1)'(1) << (WORD_W-1)) - (WORD_W+1)'(!neg_s[WORD_W]);
		clip = q_rnd > lim;
		q_fin = clip ? lim : q_rnd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[WORD_W] ? -q_fin[WORD_W-1:0] : q_fin[WORD_W-1:0];
			sat <= clip;
		end
	end

endmodule

/* rtl/bilinear_element_stiffness_top.sv */
// bilinear element stiffness top level: operand pipeline, divider lanes, output buffer
//
//   channel   dir  handshake      payload
//   element   in   valid/ready    x_left y_bottom x_right y_top coeff_a..coeff_d
//   matrix    out  valid/ready    m00..m33 degenerate saturated
//
// one element per cycle unless stalled by a full skid entry.
// depth is set by the restoring dividers, one quotient bit per stage in each of ten lanes.
// reset clears the pipeline valid bits and the output buffer valid flags only.
// a stall freezes the whole pipeline; a two-entry output buffer keeps element.ready
// off the combinational path from matrix.ready.
`timescale 1ns / 1ps
module bilinear_element_stiffness_top import bes_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bes_in_if.sink    element,
	bes_out_if.source matrix
);

	logic en, acc_in;
	logic ov_q, sv_q;
	res_t o_q, s_q, pipe_res;

	assign en = !sv_q;
	assign element.ready = en;
	assign acc_in = element.valid & en;

	coeff_vec_t kin;
	assign kin = {element.coeff_d, element.coeff_c, element.coeff_b, element.coeff_a};

	// control: valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_sd [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++)
				vld_sd[i] <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_sd[0] <= vld_s7;
			for (int i = 1; i < DIV_LAT; i++)
				vld_sd[i] <= vld_sd[i-1];
		end
	end

	// shared operand path
	logic signed [LEN_W-1:0] lx_s1, ly_s1;
	logic                    deg_s1, deg_s2, deg_s3, deg_s4, deg_s5, deg_s6, deg_s7;
	logic                    deg_sd [DIV_LAT];
	logic [MAG_W-1:0]        ax_s2, ay_s2;
	logic                    dneg_s2, dneg_s3, dneg_s4, dneg_s5, dneg_s6, dneg_s7;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3, dxy_s3;
	logic [DEN_W-1:0]        den_s4, den_s5, den_s6, den_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1  <= LEN_W'(element.x_right) - LEN_W'(element.x_left);
			ly_s1  <= LEN_W'(element.y_top) - LEN_W'(element.y_bottom);
			deg_s1 <= (element.x_right == element.x_left) || (element.y_top == element.y_bottom);

			ax_s2   <= lx_s1[LEN_W-1] ? MAG_W'(-lx_s1) : MAG_W'(lx_s1);
			ay_s2   <= ly_s1[LEN_W-1] ? MAG_W'(-ly_s1) : MAG_W'(ly_s1);
			dneg_s2 <= lx_s1[LEN_W-1] ^ ly_s1[LEN_W-1];
			deg_s2  <= deg_s1;

			sqx_s3  <= ax_s2 * ax_s2;
			sqy_s3  <= ay_s2 * ay_s2;
			dxy_s3  <= ax_s2 * ay_s2;
			dneg_s3 <= dneg_s2;
			deg_s3  <= deg_s2;

			// times 24 as 16 + 8
			den_s4  <= (DEN_W'(dxy_s3) << 4) + (DEN_W'(dxy_s3) << 3);
			dneg_s4 <= dneg_s3;
			deg_s4  <= deg_s3;

			den_s5  <= den_s4;
			dneg_s5 <= dneg_s4;
			deg_s5  <= deg_s4;
			den_s6  <= den_s5;
			dneg_s6 <= dneg_s5;
			deg_s6  <= deg_s5;
			den_s7  <= den_s6;
			dneg_s7 <= dneg_s6;
			deg_s7  <= deg_s6;

			deg_sd[0] <= deg_s7;
			for (int i = 1; i < DIV_LAT; i++)
				deg_sd[i] <= deg_sd[i-1];
		end
	end

	// one lane per matrix entry
	logic signed [WORD_W-1:0] quo [N_ENT];
	logic [N_ENT-1:0]         sat;

	for (genvar e = 0; e < N_ENT; e++) begin : g_ent
		logic signed [WT_W-1:0]  pw_s1, qw_s1, pw_s2, qw_s2, pw_s3, qw_s3;
		logic signed [PP_W-1:0]  pxl_s4, pxh_s4, pyl_s4, pyh_s4;
		logic signed [NUM_W-1:0] nx_s5, ny_s5, num_s6;
		logic [MAGN_W-1:0]       mag_s7;
		logic                    neg_s7;

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s1 <= wsum(kin, e, 1'b0);
				qw_s1 <= wsum(kin, e, 1'b1);
				pw_s2 <= pw_s1;
				qw_s2 <= qw_s1;
				pw_s3 <= pw_s2;
				qw_s3 <= qw_s2;

				// squares split in a low and a high part
				pxl_s4 <= pw_s3 * $signed({1'b0, sqx_s3[LO_W-1:0]});
				pxh_s4 <= pw_s3 * $signed({1'b0, sqx_s3[SQ_W-1:LO_W]});
				pyl_s4 <= qw_s3 * $signed({1'b0, sqy_s3[LO_W-1:0]});
				pyh_s4 <= qw_s3 * $signed({1'b0, sqy_s3[SQ_W-1:LO_W]});

				nx_s5 <= NUM_W'(pxl_s4) + (NUM_W'(pxh_s4) <<< LO_W);
				ny_s5 <= NUM_W'(pyl_s4) + (NUM_W'(pyh_s4) <<< LO_W);

				num_s6 <= nx_s5 + ny_s5;

				mag_s7 <= num_s6[NUM_W-1] ? MAGN_W'(-num_s6) : MAGN_W'(num_s6);
				neg_s7 <= num_s6[NUM_W-1] ^ dneg_s6;
			end
		end

		bes_div u_div (
			.clk (clk),
			.en  (en),
			.mag (mag_s7),
			.den (den_s7),
			.neg (neg_s7),
			.quo (quo[e]),
			.sat (sat[e])
		);

		assign pipe_res.m[e] = deg_sd[DIV_LAT-1] ? '0 : quo[e];
	end

	assign pipe_res.degenerate = deg_sd[DIV_LAT-1];
	assign pipe_res.saturated  = !deg_sd[DIV_LAT-1] && (|sat);

	// output register plus skid entry
	logic pv, take, load_o_pipe, load_o_skid, load_s;
	assign pv          = vld_sd[DIV_LAT-1] & en;
	assign take        = ov_q & matrix.ready;
	assign load_o_skid = take & sv_q;
	assign load_o_pipe = pv & (!ov_q | take);
	assign load_s      = pv & ov_q & !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (load_o_skid)
				sv_q <= 1'b0;
			else if (load_s)
				sv_q <= 1'b1;
			if (load_o_skid || load_o_pipe)
				ov_q <= 1'b1;
			else if (take)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_o_skid)
			o_q <= s_q;
		else if (load_o_pipe)
			o_q <= pipe_res;
		if (load_s)
			s_q <= pipe_res;
	end

	assign matrix.valid      = ov_q;
	assign matrix.m00        = o_q.m[0];
	assign matrix.m01        = o_q.m[1];
	assign matrix.m02        = o_q.m[2];
	assign matrix.m03        = o_q.m[3];
	assign matrix.m11        = o_q.m[4];
	assign matrix.m12        = o_q.m[5];
	assign matrix.m13        = o_q.m[6];
	assign matrix.m22        = o_q.m[7];
	assign matrix.m23        = o_q.m[8];
	assign matrix.m33        = o_q.m[9];
	assign matrix.degenerate = o_q.degenerate;
	assign matrix.saturated  = o_q.saturated;

endmodule
